>>> src/rsnp_pkg.sv
// ---------------------------------------------------------------------------
// rsnp_pkg: shared types and constants for the ray/sphere nearest pick
// Beat payloads, table entry layout, sequencer codes and datapath widths.
// ---------------------------------------------------------------------------
package rsnp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  // Operand width of the shared multiplier: sums of three 64-bit squares.
  localparam int MW = 66;
  localparam int PW = 2 * MW;
  localparam int RW = PW + 1;
  // Divider numerator/denominator-shift width.
  localparam int DW = MW + 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 1'b0,
    CFG_HIT_MARGIN  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic [5:0]         entry_index;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] ray_start_x;
    logic signed [31:0] ray_start_y;
    logic signed [31:0] ray_start_z;
    logic signed [31:0] ray_end_x;
    logic signed [31:0] ray_end_y;
    logic signed [31:0] ray_end_z;
  } in_beat_t;

  typedef struct packed {
    logic               hit;
    logic [6:0]         point_index;
    logic signed [31:0] t_param;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        radius;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MGO, S_MWAIT, S_CHK, S_RD, S_LD, S_EVAL, S_FIN, S_DWAIT, S_OUT
  } state_t;

  // Multiply steps, in issue order.
  typedef enum logic [3:0] {
    ST_EX, ST_EY, ST_EZ,
    ST_DX2, ST_DY2, ST_DZ2,
    ST_DXE, ST_DYE, ST_DZE,
    ST_RR, ST_LHS, ST_RHS, ST_DM2
  } step_t;

endpackage

>>> src/ray_sphere_nearest_pick_top.sv
// ---------------------------------------------------------------------------
// ray_sphere_nearest_pick_top: nearest sphere hit along a ray segment
// Sphere table in a synchronous memory, a sequencer that walks the active
// entries through one shared serial multiplier, and a serial divider for t.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+---------------------------
//  in      | sink      | in_valid/in_stall   | in_beat_t (write or query)
//  out     | source    | out_valid/out_stall | out_beat_t (one per query)
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A write beat is written to the table when it is accepted. A query first
//  forms the squared ray length, then evaluates each active entry, all on the
//  shared bit-serial multiplier (MW = 66), and divides for t on a hit.
//  rst is synchronous; the table is not cleared (entries are undefined until
//  written). A new beat is taken while a result still waits on out_stall.
//
module ray_sphere_nearest_pick_top #(
  parameter int MAX_POINTS = rsnp_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = rsnp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  rsnp_pkg::in_beat_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output rsnp_pkg::out_beat_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rsnp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsnp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int MW = rsnp_pkg::MW;
  localparam int PW = rsnp_pkg::PW;
  localparam int RW = rsnp_pkg::RW;
  localparam int DW = rsnp_pkg::DW;

  rsnp_pkg::state_t state, state_next;
  rsnp_pkg::step_t  step;

  // Configuration registers
  logic [6:0]  point_count;
  logic [30:0] hit_margin;

  // Query context
  logic signed [31:0] sx, sy, sz;
  logic [32:0]        emx, emy, emz;
  logic               enx, eny, enz;
  logic [6:0]         n_act;
  logic [6:0]         idx;

  // Per-entry working set
  logic [32:0] dmx, dmy, dmz;
  logic        dnx, dny, dnz;
  logic [31:0] rr;
  logic [MW-1:0] ab2, ap2, pos, neg;
  logic [63:0]   r2;
  logic [PW-1:0] lhs;
  logic [RW-1:0] rhs;

  // Best hit so far
  logic          found;
  logic [6:0]    best_idx;
  logic [MW-1:0] best_mag;
  logic          best_neg;
  logic [31:0]   tval;

  logic [MW-1:0] dm;
  logic          dneg;
  logic          hit;
  logic          in_acc;
  logic          wr_en;
  logic [6:0]    n_eff;

  rsnp_pkg::entry_t wr_entry, rd_entry;

  logic          mul_start, mul_done;
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] mul_prod;
  logic          div_start, div_done;
  logic [DW-1:0] div_num;
  logic [31:0]   div_quo;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign wr_en     = in_acc && (in_data.operation == rsnp_pkg::OP_WRITE)
                     && (int'(in_data.entry_index) < MAX_POINTS);
  assign n_eff     = (int'(point_count) > MAX_POINTS) ? 7'(MAX_POINTS) : point_count;

  assign wr_entry.cx     = in_data.center_x;
  assign wr_entry.cy     = in_data.center_y;
  assign wr_entry.cz     = in_data.center_z;
  assign wr_entry.radius = in_data.sphere_radius;

  rsnp_table #(.DEPTH(MAX_POINTS), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (wr_entry),
    .rd_addr (AW'(idx)),
    .rd_data (rd_entry)
  );

  rsnp_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign div_num = DW'(best_mag) << FRAC_BITS;

  rsnp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (ab2),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Signed projection (C-S).(E-S) as magnitude and sign
  assign dneg = pos < neg;
  assign dm   = dneg ? (neg - pos) : (pos - neg);
  // Zero-length ray: compare |S-C|^2 against r^2 directly
  assign hit  = (ab2 == '0) ? (ap2 < MW'(r2)) : (RW'(lhs) < rhs);

  always_comb begin
    mul_a = MW'(emx);
    mul_b = MW'(emx);
    case (step)
      rsnp_pkg::ST_EX:  begin mul_a = MW'(emx); mul_b = MW'(emx); end
      rsnp_pkg::ST_EY:  begin mul_a = MW'(emy); mul_b = MW'(emy); end
      rsnp_pkg::ST_EZ:  begin mul_a = MW'(emz); mul_b = MW'(emz); end
      rsnp_pkg::ST_DX2: begin mul_a = MW'(dmx); mul_b = MW'(dmx); end
      rsnp_pkg::ST_DY2: begin mul_a = MW'(dmy); mul_b = MW'(dmy); end
      rsnp_pkg::ST_DZ2: begin mul_a = MW'(dmz); mul_b = MW'(dmz); end
      rsnp_pkg::ST_DXE: begin mul_a = MW'(dmx); mul_b = MW'(emx); end
      rsnp_pkg::ST_DYE: begin mul_a = MW'(dmy); mul_b = MW'(emy); end
      rsnp_pkg::ST_DZE: begin mul_a = MW'(dmz); mul_b = MW'(emz); end
      rsnp_pkg::ST_RR:  begin mul_a = MW'(rr);  mul_b = MW'(rr);  end
      rsnp_pkg::ST_LHS: begin mul_a = ap2;      mul_b = ab2;      end
      rsnp_pkg::ST_RHS: begin mul_a = MW'(r2);  mul_b = ab2;      end
      rsnp_pkg::ST_DM2: begin mul_a = dm;       mul_b = dm;       end
      default:          begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    in_stall   = 1'b1;
    unique case (state)
      rsnp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (in_data.operation == rsnp_pkg::OP_QUERY)) begin
          state_next = rsnp_pkg::S_MGO;
        end
      end
      rsnp_pkg::S_MGO: begin
        mul_start  = 1'b1;
        state_next = rsnp_pkg::S_MWAIT;
      end
      rsnp_pkg::S_MWAIT: begin
        if (mul_done) begin
          if (step == rsnp_pkg::ST_EZ) begin
            state_next = rsnp_pkg::S_CHK;
          end else if (step == rsnp_pkg::ST_DM2) begin
            state_next = rsnp_pkg::S_EVAL;
          end else begin
            state_next = rsnp_pkg::S_MGO;
          end
        end
      end
      rsnp_pkg::S_CHK: begin
        state_next = (idx == n_act) ? rsnp_pkg::S_FIN : rsnp_pkg::S_RD;
      end
      rsnp_pkg::S_RD:   state_next = rsnp_pkg::S_LD;
      rsnp_pkg::S_LD:   state_next = rsnp_pkg::S_MGO;
      rsnp_pkg::S_EVAL: state_next = rsnp_pkg::S_CHK;
      rsnp_pkg::S_FIN: begin
        if (found && (ab2 != '0) && (best_mag != '0)) begin
          div_start  = 1'b1;
          state_next = rsnp_pkg::S_DWAIT;
        end else begin
          state_next = rsnp_pkg::S_OUT;
        end
      end
      rsnp_pkg::S_DWAIT: begin
        if (div_done) begin
          state_next = rsnp_pkg::S_OUT;
        end
      end
      rsnp_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = rsnp_pkg::S_IDLE;
        end
      end
      default: state_next = rsnp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rsnp_pkg::S_IDLE;
      point_count <= '0;
      hit_margin  <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rsnp_pkg::CFG_POINT_COUNT: point_count <= cfg_data[6:0];
          rsnp_pkg::CFG_HIT_MARGIN:  hit_margin  <= cfg_data[30:0];
          default: ;
        endcase
      end
      if ((state == rsnp_pkg::S_OUT) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a - b as sign and 33-bit magnitude
  function automatic logic [33:0] mag_sign(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    mag_sign = {d[32], d[32] ? 33'(-d) : 33'(d)};
  endfunction

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      rsnp_pkg::S_IDLE: begin
        sx <= in_data.ray_start_x;
        sy <= in_data.ray_start_y;
        sz <= in_data.ray_start_z;
        {enx, emx} <= mag_sign(in_data.ray_end_x, in_data.ray_start_x);
        {eny, emy} <= mag_sign(in_data.ray_end_y, in_data.ray_start_y);
        {enz, emz} <= mag_sign(in_data.ray_end_z, in_data.ray_start_z);
        ab2      <= '0;
        idx      <= '0;
        found    <= 1'b0;
        best_idx <= '0;
        best_mag <= '0;
        best_neg <= 1'b0;
        n_act    <= n_eff;
        step     <= rsnp_pkg::ST_EX;
      end
      rsnp_pkg::S_MWAIT: begin
        if (mul_done) begin
          case (step) inside
            rsnp_pkg::ST_EX, rsnp_pkg::ST_EY, rsnp_pkg::ST_EZ:
              ab2 <= ab2 + mul_prod[MW-1:0];
            rsnp_pkg::ST_DX2, rsnp_pkg::ST_DY2, rsnp_pkg::ST_DZ2:
              ap2 <= ap2 + mul_prod[MW-1:0];
            rsnp_pkg::ST_DXE: begin
              if (dnx != enx) neg <= neg + mul_prod[MW-1:0];
              else            pos <= pos + mul_prod[MW-1:0];
            end
            rsnp_pkg::ST_DYE: begin
              if (dny != eny) neg <= neg + mul_prod[MW-1:0];
              else            pos <= pos + mul_prod[MW-1:0];
            end
            rsnp_pkg::ST_DZE: begin
              if (dnz != enz) neg <= neg + mul_prod[MW-1:0];
              else            pos <= pos + mul_prod[MW-1:0];
            end
            rsnp_pkg::ST_RR:  r2  <= mul_prod[63:0];
            rsnp_pkg::ST_LHS: lhs <= mul_prod;
            rsnp_pkg::ST_RHS: rhs <= RW'(mul_prod);
            rsnp_pkg::ST_DM2: rhs <= rhs + RW'(mul_prod);
            default: ;
          endcase
          if ((step != rsnp_pkg::ST_EZ) && (step != rsnp_pkg::ST_DM2)) begin
            step <= rsnp_pkg::step_t'(step + 4'd1);
          end
        end
      end
      rsnp_pkg::S_LD: begin
        {dnx, dmx} <= mag_sign(rd_entry.cx, sx);
        {dny, dmy} <= mag_sign(rd_entry.cy, sy);
        {dnz, dmz} <= mag_sign(rd_entry.cz, sz);
        rr   <= 32'(rd_entry.radius) + 32'(hit_margin);
        ap2  <= '0;
        pos  <= '0;
        neg  <= '0;
        step <= rsnp_pkg::ST_DX2;
      end
      rsnp_pkg::S_EVAL: begin
        if (hit && (!found || (dm < best_mag))) begin
          found    <= 1'b1;
          best_idx <= idx;
          best_mag <= dm;
          best_neg <= dneg;
        end
        idx <= idx + 7'd1;
      end
      rsnp_pkg::S_FIN: tval <= '0;
      rsnp_pkg::S_DWAIT: begin
        if (div_done) begin
          if (!best_neg) begin
            tval <= div_quo[31] ? 32'h7FFF_FFFF : div_quo;
          end else begin
            tval <= div_quo[31] ? 32'h8000_0000 : (32'd0 - div_quo);
          end
        end
      end
      rsnp_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_data.hit         <= found;
          out_data.point_index <= found ? best_idx : (n_act + 7'd1);
          out_data.t_param     <= found ? tval : 32'sd0;
        end
      end
      default: ;
    endcase
  end

  // Serial units only finish while the sequencer waits on them
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == rsnp_pkg::S_MWAIT)
    else $error("multiplier done outside wait");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == rsnp_pkg::S_DWAIT)
    else $error("divider done outside wait");

  a_miss_t: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.t_param == 32'sd0)
    else $error("miss with nonzero t");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == rsnp_pkg::S_CHK |-> idx <= n_act)
    else $error("entry walk past active count");

endmodule

>>> src/rsnp_table.sv
// ---------------------------------------------------------------------------
// rsnp_table: sphere table storage
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module rsnp_table #(
  parameter int DEPTH = rsnp_pkg::MAX_POINTS_DEF,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  rsnp_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output rsnp_pkg::entry_t rd_data
);

  rsnp_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/rsnp_mul.sv
// ---------------------------------------------------------------------------
// rsnp_mul: shift-add multiplier
// Unsigned W x W, one multiplier bit per cycle, done pulses with product.
// ---------------------------------------------------------------------------
module rsnp_mul #(
  parameter int W = rsnp_pkg::MW
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic           busy;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod   <= '0;
      mcand  <= (2*W)'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        prod <= prod + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

>>> src/rsnp_div.sv
// ---------------------------------------------------------------------------
// rsnp_div: restoring divider, 32-bit quotient
// One quotient bit per cycle; quotient saturates to all ones on overflow.
// ---------------------------------------------------------------------------
module rsnp_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rsnp_pkg::DW-1:0] num,
  input  logic [rsnp_pkg::MW-1:0] den,
  output logic                   done,
  output logic [31:0]            quo
);

  localparam int DW = rsnp_pkg::DW;

  logic          busy;
  logic [5:0]    cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [DW-1:0] den_full;

  assign den_full = DW'(den) << 32;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num >= den_full) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= 6'd32;
        end
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= DW'(den) << 31;
      quo <= (num >= den_full) ? 32'hFFFF_FFFF : 32'd0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[30:0], 1'b1};
      end else begin
        quo <= {quo[30:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule
